### rtl/rfr_pkg.sv
// shared constants, types and crc helper for the response frame reassembler
package rfr_pkg;

  // payload store geometry
  localparam int STORE_DEPTH = 512;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // frame layout
  localparam int HDR_LEN   = 8;
  localparam int LEN_POS   = 7;
  localparam int TRAIL_LEN = 3;
  localparam int FILL_W    = 9;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // request commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_INCOMPLETE = 3'd0;
  localparam logic [2:0] ST_COMPLETE   = 3'd1;
  localparam logic [2:0] ST_BAD_TERM   = 3'd2;
  localparam logic [2:0] ST_CRC_ERR    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_HEAD     = 2'd0;
  localparam logic [1:0] REG_TERM     = 2'd1;
  localparam logic [1:0] REG_CMD_OFS  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  // configuration reset values
  localparam logic [7:0]  HEAD_RST    = 8'h7E;
  localparam logic [7:0]  TERM_RST    = 8'h0D;
  localparam logic [2:0]  CMD_OFS_RST = 3'd5;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  terminator_byte;
    logic [2:0]  command_offset;
    logic [15:0] timeout_ms;
  } cfg_t;

  // result of one request before the payload store read returns
  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        frame_command;
    logic [7:0]        payload_length;
    logic              rd_en;
    logic [31:0]       discarded_total;
    logic [FILL_W-1:0] buffered_count;
  } result_t;

  // one byte of crc-16/modbus, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/rfr_if.sv
// request, result and configuration channel interfaces

interface rfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_byte;
  logic [31:0] now_ms;
  logic [7:0]  read_index;

  modport source (output valid, cmd, data_byte, now_ms, read_index, input ready);
  modport sink (input valid, cmd, data_byte, now_ms, read_index, output ready);
endinterface

interface rfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_command;
  logic [7:0]  payload_length;
  logic [7:0]  read_data;
  logic [31:0] discarded_total;
  logic [8:0]  buffered_count;

  modport source (output valid, status, frame_command, payload_length, read_data,
                  discarded_total, buffered_count, input ready);
  modport sink (input valid, status, frame_command, payload_length, read_data,
                discarded_total, buffered_count, output ready);
endinterface

interface rfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/rfr_cfg_regs.sv
// configuration register bank
module rfr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  rfr_cfg_if.sink       cfg_ch,
  output rfr_pkg::cfg_t cfg
);

  rfr_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte       <= rfr_pkg::HEAD_RST;
      cfg_r.terminator_byte <= rfr_pkg::TERM_RST;
      cfg_r.command_offset  <= rfr_pkg::CMD_OFS_RST;
      cfg_r.timeout_ms      <= rfr_pkg::TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        rfr_pkg::REG_HEAD:    cfg_r.head_byte       <= cfg_ch.wdata[7:0];
        rfr_pkg::REG_TERM:    cfg_r.terminator_byte <= cfg_ch.wdata[7:0];
        rfr_pkg::REG_CMD_OFS: cfg_r.command_offset  <= cfg_ch.wdata[2:0];
        rfr_pkg::REG_TIMEOUT: cfg_r.timeout_ms      <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/rfr_frame_store.sv
// frame byte store, one write port and one registered read port
module rfr_frame_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [rfr_pkg::STORE_AW-1:0] wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [rfr_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                   rd_data_r
);

  logic [7:0] mem [rfr_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/rfr_core.sv
// frame tracking: fill count, crc, timing, discard counter and store addressing
module rfr_core (
  input  logic                         clk,
  input  logic                         rst_n,
  rfr_in_if.sink                       in_ch,
  input  logic                         take_ok,
  input  rfr_pkg::cfg_t                cfg,
  output logic                         acc,
  output rfr_pkg::result_t             res,
  output logic                         wr_en,
  output logic [rfr_pkg::STORE_AW-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output logic                         rd_en,
  output logic [rfr_pkg::STORE_AW-1:0] rd_addr
);

  localparam int FW = rfr_pkg::FILL_W;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   disc_r, disc_nxt;
  logic [7:0]    lcmd_r, lcmd_nxt;
  logic [7:0]    llen_r, llen_nxt;
  logic [7:0]    hdr_r [rfr_pkg::HDR_LEN];
  logic [7:0]    prev1_r, prev1_nxt;
  logic [7:0]    prev2_r, prev2_nxt;

  logic          is_empty;
  logic          in_hdr;
  logic          in_body;
  logic          hdr_we;
  logic          byte_we;
  logic          rd_req;
  logic [FW-1:0] fill_inc;
  logic [FW-1:0] body_end;
  logic [FW-1:0] frame_total;
  logic [7:0]    frame_len;
  logic [15:0]   crc_upd;
  logic [31:0]   elapsed;
  logic [FW-1:0] disc_add;
  logic [32:0]   disc_sum;
  logic [2:0]    status;

  assign acc         = in_ch.valid & take_ok;
  assign in_ch.ready = take_ok;

  // frame geometry from the buffered length byte
  assign is_empty    = (fill_r == '0);
  assign fill_inc    = fill_r + FW'(1);
  assign frame_len   = hdr_r[rfr_pkg::LEN_POS];
  assign body_end    = FW'(rfr_pkg::HDR_LEN) + FW'(frame_len);
  assign frame_total = body_end + FW'(rfr_pkg::TRAIL_LEN);
  assign in_hdr      = (fill_r < FW'(rfr_pkg::HDR_LEN));
  assign in_body     = (fill_r < body_end);
  assign crc_upd     = rfr_pkg::crc_byte(crc_r, in_ch.data_byte);
  assign elapsed     = in_ch.now_ms - start_r;

  // next state for the request on the channel
  always_comb begin
    fill_nxt  = fill_r;
    crc_nxt   = crc_r;
    start_nxt = start_r;
    lcmd_nxt  = lcmd_r;
    llen_nxt  = llen_r;
    prev1_nxt = prev1_r;
    prev2_nxt = prev2_r;
    disc_add  = '0;
    hdr_we    = 1'b0;
    byte_we   = 1'b0;
    rd_req    = 1'b0;
    status    = rfr_pkg::ST_INCOMPLETE;
    case (in_ch.cmd)
      rfr_pkg::CMD_BYTE: begin
        if (is_empty && (in_ch.data_byte != cfg.head_byte)) begin
          // stray byte while idle
          disc_add = FW'(1);
        end else begin
          byte_we   = 1'b1;
          hdr_we    = in_hdr;
          fill_nxt  = fill_inc;
          prev1_nxt = in_ch.data_byte;
          prev2_nxt = prev1_r;
          if (in_hdr || in_body) begin
            crc_nxt = crc_upd;
          end
          if (is_empty) begin
            start_nxt = in_ch.now_ms;
          end
          // last byte of the frame: terminator first, then crc
          if (!in_hdr && (fill_inc == frame_total)) begin
            if (in_ch.data_byte != cfg.terminator_byte) begin
              status   = rfr_pkg::ST_BAD_TERM;
              disc_add = frame_total;
            end else if (crc_r != {prev2_r, prev1_r}) begin
              status   = rfr_pkg::ST_CRC_ERR;
              disc_add = frame_total;
            end else begin
              status   = rfr_pkg::ST_COMPLETE;
              lcmd_nxt = hdr_r[cfg.command_offset];
              llen_nxt = frame_len;
            end
            fill_nxt = '0;
            crc_nxt  = rfr_pkg::CRC_INIT;
          end
        end
      end
      rfr_pkg::CMD_TICK: begin
        if (!is_empty && (elapsed >= {16'h0000, cfg.timeout_ms})) begin
          status   = rfr_pkg::ST_TIMEOUT;
          disc_add = fill_r;
          fill_nxt = '0;
          crc_nxt  = rfr_pkg::CRC_INIT;
        end
      end
      rfr_pkg::CMD_READ: begin
        rd_req = (in_ch.read_index < llen_r);
      end
      rfr_pkg::CMD_CLEAR: begin
        fill_nxt  = '0;
        crc_nxt   = rfr_pkg::CRC_INIT;
        start_nxt = '0;
        lcmd_nxt  = '0;
        llen_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // saturating discard counter
  assign disc_sum = {1'b0, disc_r} + 33'(disc_add);
  assign disc_nxt = disc_sum[32] ? '1 : disc_sum[31:0];

  // store access
  assign wr_en   = acc & byte_we;
  assign wr_addr = rfr_pkg::STORE_AW'(fill_r);
  assign wr_data = in_ch.data_byte;
  assign rd_en   = acc & rd_req;
  assign rd_addr = rfr_pkg::STORE_AW'(FW'(rfr_pkg::HDR_LEN) + FW'(in_ch.read_index));

  // result fields
  assign res.status          = status;
  assign res.frame_command   = lcmd_nxt;
  assign res.payload_length  = llen_nxt;
  assign res.rd_en           = rd_req;
  assign res.discarded_total = disc_nxt;
  assign res.buffered_count  = fill_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      crc_r   <= rfr_pkg::CRC_INIT;
      start_r <= '0;
      disc_r  <= '0;
      lcmd_r  <= '0;
      llen_r  <= '0;
    end else if (acc) begin
      fill_r  <= fill_nxt;
      crc_r   <= crc_nxt;
      start_r <= start_nxt;
      disc_r  <= disc_nxt;
      lcmd_r  <= lcmd_nxt;
      llen_r  <= llen_nxt;
    end
  end

  // header bytes and the last two received bytes
  always_ff @(posedge clk) begin
    if (acc) begin
      prev1_r <= prev1_nxt;
      prev2_r <= prev2_nxt;
      if (hdr_we) begin
        hdr_r[fill_r[$clog2(rfr_pkg::HDR_LEN)-1:0]] <= in_ch.data_byte;
      end
    end
  end

endmodule

### rtl/rfr_out_stage.sv
// result pipeline: store read stage, then output register
module rfr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  rfr_pkg::result_t res_in,
  input  logic [7:0]       rd_data,
  output logic             take_ok,
  rfr_out_if.source        out_ch
);

  rfr_pkg::result_t s1_r;
  rfr_pkg::result_t out_r;
  logic             s1_v_r;
  logic             out_v_r;
  logic [7:0]       rdata_r;
  logic             out_free;
  logic             s1_move;

  assign out_free = !out_v_r || out_ch.ready;
  assign s1_move  = s1_v_r && out_free;
  assign take_ok  = !s1_v_r || out_free;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc || (s1_v_r && !s1_move);
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= res_in;
    end
    if (s1_move) begin
      out_r   <= s1_r;
      rdata_r <= s1_r.rd_en ? rd_data : 8'h00;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.frame_command   = out_r.frame_command;
  assign out_ch.payload_length  = out_r.payload_length;
  assign out_ch.read_data       = rdata_r;
  assign out_ch.discarded_total = out_r.discarded_total;
  assign out_ch.buffered_count  = out_r.buffered_count;

endmodule

### rtl/response_frame_reassembler.sv
// top level of the response frame reassembler
// Rebuilds length-prefixed response frames (8-byte header opening with the
// head byte, payload length in byte 7, payload, big-endian crc-16/modbus,
// terminator) from a stream of byte, tick, read and clear requests. One
// request is taken every clock cycle while the result stages have room; each
// gives one result via a stage register, joined by the registered store read
// for read requests, then an output register. The store has no reset value
// and needs no clearing pass: reads only reach bytes written since reset.
// Configuration writes belong to idle periods with no result outstanding.
module response_frame_reassembler (
  input  logic       clk,
  input  logic       rst_n,
  rfr_in_if.sink     in_ch,
  rfr_out_if.source  out_ch,
  rfr_cfg_if.sink    cfg_ch
);

  rfr_pkg::cfg_t                cfg;
  rfr_pkg::result_t             res;
  logic                         acc;
  logic                         take_ok;
  logic                         wr_en;
  logic [rfr_pkg::STORE_AW-1:0] wr_addr;
  logic [7:0]                   wr_data;
  logic                         rd_en;
  logic [rfr_pkg::STORE_AW-1:0] rd_addr;
  logic [7:0]                   rd_data;

  rfr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take_ok (take_ok),
    .cfg     (cfg),
    .acc     (acc),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  rfr_frame_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  rfr_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .res_in  (res),
    .rd_data (rd_data),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

### tb/tb_response_frame_reassembler.sv
// self-checking testbench for the response frame reassembler
`timescale 1ns / 1ps

module tb_response_frame_reassembler;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SEGMENT_ITEMS = 80;
  localparam int SETTLE_CYCLES = 4;

  // one request as it crosses the input channel
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
    logic [7:0]  read_index;
  } request_t;

  // one result as it crosses the output channel
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame_command;
    logic [7:0]  payload_length;
    logic [7:0]  read_data;
    logic [31:0] discarded_total;
    logic [8:0]  buffered_count;
  } outcome_t;

  // ways a generated frame can be spoiled
  typedef enum {FRAME_GOOD, FRAME_BAD_TERM, FRAME_BAD_CRC, FRAME_BAD_BOTH} frame_flaw_t;

  // frame reassembly predictor and queue of expected outcomes
  class frame_scoreboard;
    logic [7:0]     store_mem [rfr_pkg::STORE_DEPTH];
    int unsigned    fill;
    logic [15:0]    crc_acc;
    bit             timing;
    logic [31:0]    start_ms;
    logic [31:0]    discards;
    logic [7:0]     last_cmd;
    logic [7:0]     last_len;
    rfr_pkg::cfg_t  cfg;
    outcome_t       pending_q[$];
    int             errors;

    function new();
      foreach (store_mem[i]) store_mem[i] = 8'h00;
      fill     = 0;
      crc_acc  = rfr_pkg::CRC_INIT;
      timing   = 1'b0;
      start_ms = '0;
      discards = '0;
      last_cmd = '0;
      last_len = '0;
      cfg.head_byte       = rfr_pkg::HEAD_RST;
      cfg.terminator_byte = rfr_pkg::TERM_RST;
      cfg.command_offset  = rfr_pkg::CMD_OFS_RST;
      cfg.timeout_ms      = rfr_pkg::TIMEOUT_RST;
      errors   = 0;
    endfunction

    // crc-16/modbus, one data bit folded in per shift
    static function logic [15:0] crc_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ b[i]) r = (r >> 1) ^ rfr_pkg::CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        rfr_pkg::REG_HEAD:    cfg.head_byte       = val[7:0];
        rfr_pkg::REG_TERM:    cfg.terminator_byte = val[7:0];
        rfr_pkg::REG_CMD_OFS: cfg.command_offset  = val[2:0];
        rfr_pkg::REG_TIMEOUT: cfg.timeout_ms      = val;
        default: ;
      endcase
    endfunction

    // saturating discard counter
    function void add_discard(logic [31:0] n);
      logic [32:0] sum;
      sum = {1'b0, discards} + {1'b0, n};
      discards = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function void drop_partial();
      fill    = 0;
      timing  = 1'b0;
      crc_acc = rfr_pkg::CRC_INIT;
    endfunction

    function logic [2:0] absorb_byte(logic [7:0] b, logic [31:0] now);
      int unsigned pos;
      int unsigned total;
      bit          idle_before;
      logic [2:0]  st;
      logic [15:0] sent_crc;
      st = rfr_pkg::ST_INCOMPLETE;
      idle_before = (fill == 0);
      // idle: anything but the head byte is dropped
      if (idle_before && b != cfg.head_byte) begin
        add_discard(1);
        return st;
      end
      pos = fill;
      store_mem[pos] = b;
      fill = pos + 1;
      // crc runs over header and payload only
      if (pos < rfr_pkg::HDR_LEN || pos < rfr_pkg::HDR_LEN + store_mem[rfr_pkg::LEN_POS])
        crc_acc = crc_next(crc_acc, b);
      if (fill >= rfr_pkg::HDR_LEN) begin
        total = rfr_pkg::HDR_LEN + store_mem[rfr_pkg::LEN_POS] + rfr_pkg::TRAIL_LEN;
        if (fill >= total) begin
          sent_crc = {store_mem[total - 3], store_mem[total - 2]};
          if (store_mem[total - 1] != cfg.terminator_byte) begin
            add_discard(total);
            st = rfr_pkg::ST_BAD_TERM;
          end else if (crc_acc != sent_crc) begin
            add_discard(total);
            st = rfr_pkg::ST_CRC_ERR;
          end else begin
            last_cmd = store_mem[cfg.command_offset];
            last_len = store_mem[rfr_pkg::LEN_POS];
            st = rfr_pkg::ST_COMPLETE;
          end
          drop_partial();
        end
      end
      // frame age counts from its first byte
      if (fill > 0 && (idle_before || !timing)) begin
        start_ms = now;
        timing   = 1'b1;
      end
      return st;
    endfunction

    function void note_request(request_t r);
      outcome_t    o;
      logic [31:0] age;
      o = '0;
      case (r.cmd)
        rfr_pkg::CMD_BYTE: o.status = absorb_byte(r.data_byte, r.now_ms);
        rfr_pkg::CMD_TICK: begin
          age = r.now_ms - start_ms;
          if (fill != 0 && timing && age >= {16'h0000, cfg.timeout_ms}) begin
            add_discard(fill);
            drop_partial();
            o.status = rfr_pkg::ST_TIMEOUT;
          end
        end
        rfr_pkg::CMD_READ: begin
          if (r.read_index < last_len)
            o.read_data = store_mem[rfr_pkg::HDR_LEN + r.read_index];
        end
        default: begin
          drop_partial();
          start_ms = '0;
          last_cmd = '0;
          last_len = '0;
        end
      endcase
      o.frame_command   = last_cmd;
      o.payload_length  = last_len;
      o.discarded_total = discards;
      o.buffered_count  = fill[8:0];
      pending_q.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("frame_command", want.frame_command, got.frame_command);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("discarded_total", want.discarded_total, got.discarded_total);
      compare_field("buffered_count", want.buffered_count, got.buffered_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rfr_in_if  in_ch ();
  rfr_out_if out_ch ();
  rfr_cfg_if cfg_ch ();

  frame_scoreboard sb = new();

  int          tx_idle_pct = 7;
  int          rx_idle_pct = 59;
  int          items_sent  = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms    = 32'hFFFF_F000;
  outcome_t    seen;

  response_frame_reassembler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.status          = out_ch.status;
      seen.frame_command   = out_ch.frame_command;
      seen.payload_length  = out_ch.payload_length;
      seen.read_data       = out_ch.read_data;
      seen.discarded_total = out_ch.discarded_total;
      seen.buffered_count  = out_ch.buffered_count;
      sb.check_result(seen);
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic drive_item(logic [1:0] cmd, logic [7:0] data, logic [31:0] now,
                            logic [7:0] ridx);
    request_t req;
    req.cmd        = cmd;
    req.data_byte  = data;
    req.now_ms     = now;
    req.read_index = ridx;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.data_byte  <= data;
    in_ch.now_ms     <= now;
    in_ch.read_index <= ridx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(req);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    logic [31:0] now;
    clock_ms += $urandom_range(3);
    now = ($urandom_range(9) == 0) ? $urandom : clock_ms;
    drive_item(rfr_pkg::CMD_BYTE, b, now, 8'($urandom));
  endtask

  task automatic send_clear();
    drive_item(rfr_pkg::CMD_CLEAR, 8'($urandom), $urandom, 8'($urandom));
  endtask

  // tick relative to the start of the held frame, old enough or not
  task automatic send_tick(bit expire);
    logic [31:0] age;
    if (expire) begin
      age = ($urandom_range(3) == 0) ? $urandom : sb.cfg.timeout_ms + $urandom_range(3000);
      if (age < sb.cfg.timeout_ms) age = sb.cfg.timeout_ms;
    end else begin
      age = (sb.cfg.timeout_ms == 0) ? 32'd0 : $urandom_range(sb.cfg.timeout_ms - 1);
    end
    drive_item(rfr_pkg::CMD_TICK, 8'($urandom), sb.start_ms + age, 8'($urandom));
  endtask

  // payload reads, mostly in range or just past the end
  task automatic send_reads(int n);
    logic [7:0] idx;
    repeat (n) begin
      idx = ($urandom_range(9) < 7) ? 8'($urandom_range(sb.last_len)) : 8'($urandom);
      drive_item(rfr_pkg::CMD_READ, 8'($urandom), $urandom, idx);
    end
  endtask

  // line noise, mostly bytes that cannot start a frame
  task automatic send_noise(int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if ($urandom_range(4) != 0 && b == sb.cfg.head_byte) b = ~b;
      send_byte(b);
    end
  endtask

  // build a frame, optionally spoiled or cut short, and send it byte by byte
  task automatic send_frame(int len, frame_flaw_t flaw, int cut, bit head_in_payload,
                            bit extras);
    logic [7:0]  bytes_q [$];
    logic [15:0] crc;
    logic [7:0]  term;
    int          n;
    bytes_q.push_back(sb.cfg.head_byte);
    repeat (rfr_pkg::HDR_LEN - 2) bytes_q.push_back(8'($urandom));
    bytes_q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      if ((head_in_payload && i == 0) || $urandom_range(15) == 0)
        bytes_q.push_back(sb.cfg.head_byte);
      else
        bytes_q.push_back(8'($urandom));
    end
    crc = rfr_pkg::CRC_INIT;
    foreach (bytes_q[i]) crc = frame_scoreboard::crc_next(crc, bytes_q[i]);
    if (flaw == FRAME_BAD_CRC || flaw == FRAME_BAD_BOTH)
      crc ^= 16'($urandom_range(16'hFFFF, 1));
    term = sb.cfg.terminator_byte;
    if (flaw == FRAME_BAD_TERM || flaw == FRAME_BAD_BOTH)
      term ^= 8'($urandom_range(8'hFF, 1));
    bytes_q.push_back(crc[15:8]);
    bytes_q.push_back(crc[7:0]);
    bytes_q.push_back(term);
    n = (cut > 0 && cut < bytes_q.size()) ? cut : bytes_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte(bytes_q[i]);
      // young ticks and reads between bytes of a partial frame
      if (extras && i + 1 < n) begin
        if ($urandom_range(99) < 3 && sb.cfg.timeout_ms != 0) send_tick(1'b0);
        else if ($urandom_range(99) < 3) send_reads(1);
      end
    end
  endtask

  // wait until every expected result is back, plus pipeline slack
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic apply_settings(logic [7:0] head, logic [7:0] term, logic [2:0] ofs,
                                logic [15:0] tmo);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs[0] = rfr_pkg::REG_HEAD;
    regs[1] = rfr_pkg::REG_TERM;
    regs[2] = rfr_pkg::REG_CMD_OFS;
    regs[3] = rfr_pkg::REG_TIMEOUT;
    vals[0] = {8'($urandom), head};
    vals[1] = {8'($urandom), term};
    vals[2] = {13'($urandom), ofs};
    vals[3] = tmo;
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= regs[i];
      cfg_ch.wdata     <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // random mix of frames, broken frames, noise, reads, ticks and clears
  task automatic run_segment(int target);
    int stop_at;
    int pick;
    int r;
    int len;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      // usually get back in step when a partial frame is held
      if (sb.fill != 0 && $urandom_range(4) != 0) begin
        if ($urandom_range(1)) send_tick(1'b1);
        else send_clear();
      end
      r = $urandom_range(99);
      len = (r < 85) ? $urandom_range(8) : (r < 98) ? $urandom_range(40, 9)
                                                    : $urandom_range(255, 200);
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_frame(len, FRAME_GOOD, 0, 1'b0, 1'b1);
        if ($urandom_range(1)) send_reads($urandom_range(4, 1));
      end else if (pick < 58) send_frame(len, FRAME_BAD_TERM, 0, 1'b0, 1'b1);
      else if (pick < 66) send_frame(len, FRAME_BAD_CRC, 0, 1'b0, 1'b1);
      else if (pick < 70) send_frame(len, FRAME_BAD_BOTH, 0, 1'b0, 1'b1);
      else if (pick < 78)
        send_frame(len, FRAME_GOOD, $urandom_range(rfr_pkg::HDR_LEN + len + 2, 1),
                   1'b0, 1'b1);
      else if (pick < 88) send_noise($urandom_range(4, 1));
      else if (pick < 94) send_reads($urandom_range(3, 1));
      else if (pick < 97) send_tick(1'($urandom_range(1)));
      else send_clear();
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd        = rfr_pkg::CMD_BYTE;
    in_ch.data_byte  = '0;
    in_ch.now_ms     = '0;
    in_ch.read_index = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = rfr_pkg::REG_HEAD;
    cfg_ch.wdata     = '0;
    rst_n            = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle drops, empty read and tick, short frame, partial frame
    apply_settings(rfr_pkg::HEAD_RST, rfr_pkg::TERM_RST, rfr_pkg::CMD_OFS_RST,
                   rfr_pkg::TIMEOUT_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    drive_item(rfr_pkg::CMD_READ, 8'h00, 32'h0000_0000, 8'h00);
    send_tick(1'b1);
    send_frame(1, FRAME_GOOD, 0, 1'b1, 1'b0);
    drive_item(rfr_pkg::CMD_READ, 8'hFF, 32'hFFFF_FFFF, 8'h00);
    drive_item(rfr_pkg::CMD_READ, 8'h00, 32'h0000_0000, 8'hFF);
    send_frame(4, FRAME_GOOD, 3, 1'b0, 1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_clear();

    // slow receiver
    tx_idle_pct = 7;
    rx_idle_pct = 59;
    apply_settings(8'h00, 8'hFF, 3'd0, 16'd1);
    run_segment(SEGMENT_ITEMS);
    apply_settings(8'hFF, 8'h00, 3'd7, 16'hFFFF);
    run_segment(SEGMENT_ITEMS);

    // slow sender
    tx_idle_pct = 59;
    rx_idle_pct = 7;
    apply_settings(8'($urandom), 8'($urandom), 3'($urandom), 16'd0);
    run_segment(SEGMENT_ITEMS);
    apply_settings(8'($urandom), 8'($urandom), 3'($urandom), 16'($urandom_range(3000, 1)));
    run_segment(SEGMENT_ITEMS);

    // full rate, including one frame of the longest payload
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(rfr_pkg::HEAD_RST, rfr_pkg::TERM_RST, rfr_pkg::CMD_OFS_RST,
                   rfr_pkg::TIMEOUT_RST);
    if (sb.fill != 0) send_clear();
    send_frame(255, FRAME_GOOD, 0, 1'b0, 1'b0);
    drive_item(rfr_pkg::CMD_READ, 8'($urandom), $urandom, 8'd254);
    drive_item(rfr_pkg::CMD_READ, 8'($urandom), $urandom, 8'd255);
    run_segment(SEGMENT_ITEMS);
    apply_settings(8'($urandom), 8'($urandom), 3'($urandom),
                   16'($urandom_range(16'hFFFF, 1)));
    run_segment(SEGMENT_ITEMS);

    settle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/rfr_pkg.sv
rtl/rfr_if.sv
rtl/rfr_cfg_regs.sv
rtl/rfr_frame_store.sv
rtl/rfr_core.sv
rtl/rfr_out_stage.sv
rtl/response_frame_reassembler.sv
tb/tb_response_frame_reassembler.sv
